@@ src/sues_pkg.sv @@
// sues_pkg: shared types and constants of the sorted unique set engine
// used by sues_cell and sorted_unique_set_engine_top; depends on nothing
package sues_pkg;

   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int ENTRY_W  = 7;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [KEY_W-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic               succeeded;
      logic               store_full;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_item_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                    cmp_en;
      logic                    ins_en;
      logic                    del_en;
      logic signed [KEY_W-1:0] key;
   } cell_cmd_type;

endpackage

@@ src/sues_cell.sv @@
// sues_cell: one slot of the sorted key chain, holds one key and its compare flags
// shifts right on insert, left on delete; depends on sues_pkg
module sues_cell
   import sues_pkg::*;
(
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  logic                    occ,
   input  logic                    prev_occ,
   input  logic                    prev_less,
   input  logic signed [KEY_W-1:0] prev_key,
   input  logic signed [KEY_W-1:0] next_key,
   output logic signed [KEY_W-1:0] key,
   output logic                    less,
   output logic                    eq
);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    less_ff, less_in;
   logic                    eq_ff, eq_in;

   always_comb begin
      less_in = less_ff;
      eq_in   = eq_ff;
      key_in  = key_ff;
      if (cmd.cmp_en) begin
         less_in = occ && (key_ff < cmd.key);
         eq_in   = occ && (key_ff == cmd.key);
      end
      if (cmd.ins_en && (occ || prev_occ) && !less_ff) begin
         key_in = prev_less ? cmd.key : prev_key;
      end else if (cmd.del_en && occ && !less_ff) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      less_ff <= less_in;
      eq_ff   <= eq_in;
   end

   assign key  = key_ff;
   assign less = less_ff;
   assign eq   = eq_ff;

endmodule

@@ src/sorted_unique_set_engine_top.sv @@
// sorted_unique_set_engine_top: controller, key count and response register
// around a chain of sues_cell slots; depends on sues_pkg and sues_cell
//
// Holds up to CAPACITY distinct signed 32-bit keys in ascending order, one key per
// cell. Each item passes through ST_CMP, where every cell compares its key with the
// request key in parallel, and ST_APPLY, where the cells shift right (insert of an
// absent key, store not full) or left (delete of a present key) by one place and the
// response is written to the output register once it is free. A new item is taken
// while idle or in the same cycle a response is written, so items do not overlap.
// The store is empty after reset and needs no clearing time.
module sorted_unique_set_engine_top
   import sues_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_APPLY} state_type;

   state_type    state_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   req_item_type item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic signed [KEY_W-1:0] key_vec [CAPACITY];
   logic [CAPACITY-1:0] less_vec, eq_vec, occ_vec;
   cell_cmd_type cmd;
   logic out_free, accept, apply_go, present, is_full;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || (state_ff == ST_APPLY && out_free));
   assign accept    = req_valid && !req_stall;
   assign apply_go  = (state_ff == ST_APPLY) && out_free;
   assign present   = |eq_vec;
   assign is_full   = (count_ff == COUNT_W'(CAPACITY));

   assign cmd.cmp_en = (state_ff == ST_CMP);
   assign cmd.ins_en = apply_go && (item_ff.kind == KIND_INSERT) && !present && !is_full;
   assign cmd.del_en = apply_go && (item_ff.kind == KIND_DELETE) && present;
   assign cmd.key    = item_ff.key;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] prev_key, next_key;
      logic                    prev_less, prev_occ;

      assign occ_vec[i] = (COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign prev_key  = '0;
         assign prev_less = 1'b1;
         assign prev_occ  = 1'b1;
      end else begin : g_rest
         assign prev_key  = key_vec[i-1];
         assign prev_less = less_vec[i-1];
         assign prev_occ  = occ_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_key = key_vec[i];
      end else begin : g_mid
         assign next_key = key_vec[i+1];
      end

      sues_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occ       (occ_vec[i]),
         .prev_occ  (prev_occ),
         .prev_less (prev_less),
         .prev_key  (prev_key),
         .next_key  (next_key),
         .key       (key_vec[i]),
         .less      (less_vec[i]),
         .eq        (eq_vec[i])
      );
   end

   always_comb begin
      count_in               = count_ff;
      rsp_item_in.succeeded  = 1'b0;
      rsp_item_in.store_full = 1'b0;
      unique case (item_ff.kind)
         KIND_INSERT: begin
            if (!present && is_full) begin
               rsp_item_in.store_full = 1'b1;
            end else if (!present) begin
               rsp_item_in.succeeded = 1'b1;
               count_in              = count_ff + COUNT_W'(1);
            end
         end
         KIND_DELETE: begin
            if (present) begin
               rsp_item_in.succeeded = 1'b1;
               count_in              = count_ff - COUNT_W'(1);
            end
         end
         KIND_SEARCH: rsp_item_in.succeeded = present;
         default: ;
      endcase
      rsp_item_in.entry_count = ENTRY_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            item_ff <= req_item;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: state_ff <= ST_APPLY;
            ST_APPLY: begin
               if (out_free) begin
                  rsp_item_ff  <= rsp_item_in;
                  count_ff     <= count_in;
                  state_ff     <= accept ? ST_CMP : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("key count above capacity");

   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CMP)
      else $error("accepted item did not enter compare");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !apply_go |=> $stable(count_ff))
      else $error("key count changed outside apply");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.succeeded && rsp_item_ff.store_full))
      else $error("response both succeeded and full");

   a_single_edit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins_en && cmd.del_en))
      else $error("insert and delete at once");

endmodule

@@ tb/sv/sues_set_checker.sv @@
// sues_set_checker: watches the request and response channels of the set engine,
// predicts every response from its own copy of the key set and compares field by field
// depends on sues_pkg
module sues_set_checker
   import sues_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           outstanding,
   output int           full_refusals,
   output int           results_checked
);

   logic signed [KEY_W-1:0] held_keys [CAPACITY];
   int                      held_count;
   rsp_item_type            outcomes_due [$];

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      full_refusals   = 0;
      results_checked = 0;
      held_count      = 0;
   end

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at result %0d: %s expected %0d got %0d",
               results_checked, what, want, got);
      fail_count++;
   endtask

   function automatic rsp_item_type apply_set_request(input req_item_type r);
      int           pos;
      bit           found;
      rsp_item_type o;
      pos = 0;
      while (pos < held_count && $signed(held_keys[pos]) < $signed(r.key))
         pos++;
      found = (pos < held_count) && (held_keys[pos] == r.key);
      o = '0;
      case (r.kind)
         KIND_INSERT: begin
            if (!found) begin
               if (held_count >= CAPACITY) begin
                  o.store_full = 1'b1;
               end else begin
                  for (int j = held_count; j > pos; j--)
                     held_keys[j] = held_keys[j-1];
                  held_keys[pos] = r.key;
                  held_count++;
                  o.succeeded = 1'b1;
               end
            end
         end
         KIND_DELETE: begin
            if (found) begin
               for (int j = pos; j + 1 < held_count; j++)
                  held_keys[j] = held_keys[j+1];
               held_count--;
               o.succeeded = 1'b1;
            end
         end
         KIND_SEARCH: o.succeeded = found;
         default: ;
      endcase
      o.entry_count = ENTRY_W'(held_count);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         held_count = 0;
         outcomes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (outcomes_due.size() == 0) begin
               report_mismatch("item with nothing due, entry_count", -1,
                               rsp_item.entry_count);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_item.succeeded !== want.succeeded)
                  report_mismatch("succeeded", want.succeeded, rsp_item.succeeded);
               if (rsp_item.store_full !== want.store_full)
                  report_mismatch("store_full", want.store_full, rsp_item.store_full);
               if (rsp_item.entry_count !== want.entry_count)
                  report_mismatch("entry_count", want.entry_count, rsp_item.entry_count);
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_set_request(req_item);
            if (want.store_full)
               full_refusals++;
            outcomes_due.push_back(want);
         end
      end
      outstanding = outcomes_due.size();
   end

endmodule

@@ tb/sv/tb_sorted_unique_set_engine_top.sv @@
// tb_sorted_unique_set_engine_top: drives insert, delete and search items into the set
// engine with random gaps and stalls and gives the verdict
// depends on sues_pkg, sorted_unique_set_engine_top and sues_set_checker
module tb_sorted_unique_set_engine_top;
   import sues_pkg::*;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int         POOL_SIZE = 96;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   int fail_count;
   int outstanding;
   int full_refusals;
   int results_checked;
   int items_sent = 0;
   bit steady     = 1'b0;

   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   sorted_unique_set_engine_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   sues_set_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .full_refusals   (full_refusals),
      .results_checked (results_checked)
   );

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 24);
   end

   task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] k);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{kind: op, key: k};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   function automatic logic [1:0] pick_kind(input int w_ins, input int w_del, input int w_srch);
      int roll;
      roll = $urandom_range(99);
      if (roll < w_ins)
         return KIND_INSERT;
      if (roll < w_ins + w_del)
         return KIND_DELETE;
      if (roll < w_ins + w_del + w_srch)
         return KIND_SEARCH;
      return KIND_NONE;
   endfunction

   function automatic logic [KEY_W-1:0] pool_key();
      return key_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   initial begin
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      key_pool[4] = 32'h0000_0001;
      key_pool[5] = 32'h8000_0001;
      key_pool[6] = 32'h7fff_fffe;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, then extremes, duplicates, hits and misses
      send_item(KIND_SEARCH, 32'h8000_0000);
      send_item(KIND_DELETE, 32'h0000_0000);
      send_item(KIND_NONE,   32'h0000_0000);
      send_item(KIND_INSERT, 32'h0000_0000);
      send_item(KIND_INSERT, 32'h8000_0000);
      send_item(KIND_INSERT, 32'h7fff_ffff);
      send_item(KIND_INSERT, 32'hffff_ffff);
      send_item(KIND_INSERT, 32'h0000_0001);
      send_item(KIND_INSERT, 32'h0000_0000);
      send_item(KIND_SEARCH, 32'h8000_0000);
      send_item(KIND_SEARCH, 32'h7fff_ffff);
      send_item(KIND_SEARCH, 32'h0000_0002);
      send_item(KIND_DELETE, 32'hffff_ffff);
      send_item(KIND_DELETE, 32'hffff_ffff);
      send_item(KIND_NONE,   32'h7fff_ffff);
      send_item(KIND_DELETE, 32'h8000_0000);
      send_item(KIND_DELETE, 32'h7fff_ffff);
      send_item(KIND_INSERT, 32'h8000_0001);
      send_item(KIND_SEARCH, 32'h7fff_fffe);

      repeat (120) send_item(pick_kind(40, 25, 30), pool_key());

      // fill past capacity with no gaps or stalls, then inserts and searches of pool keys into a full store
      steady <= 1'b1;
      for (int i = 0; i < POOL_SIZE; i++)
         send_item(KIND_INSERT, key_pool[i]);
      repeat (40) send_item(pick_kind(70, 0, 25), pool_key());
      steady <= 1'b0;
      wait_for_drain();

      repeat (100) send_item(pick_kind(10, 60, 25), pool_key());
      repeat (130) send_item(pick_kind(30, 25, 25),
                             $urandom_range(1) ? pool_key() : $urandom);

      wait_for_drain();
      repeat (20) @(negedge clock);

      $display("sent %0d items, checked %0d results", items_sent, results_checked);
      $display("%0d inserts were refused by a full store", full_refusals);
      if (fail_count == 0) begin
         $display("sorted_unique_set_engine_top verification clean");
      end else begin
         $display("sorted_unique_set_engine_top verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("sorted_unique_set_engine_top verification failed");
      $finish;
   end

endmodule
